// ----- hw/rtl/divider_and_timer_unit_defines.svh -----
// Assertion macros shared by the divider and timer unit RTL.
// No dependencies; define ASSERT_OFF to compile every check away.
`ifndef DIVIDER_AND_TIMER_UNIT_DEFINES_SVH
`define DIVIDER_AND_TIMER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked check, disabled while reset is asserted.
`define DTU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define DTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DTU_ASSERT(lbl, clk, rst_n, prop, msg)
`define DTU_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/dtu_pkg.sv -----
// Shared types and constants of the divider and timer unit.
// No dependencies; imported by every module of the block.
package dtu_pkg;

  localparam int unsigned ACCUM_W  = 9;   // divider accumulator width
  localparam int unsigned CNT_W    = 17;  // timer down-counter, sign bit on top
  localparam int unsigned PERIOD_W = 11;  // widest timer period is 1024

  // Request function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_TIMA = 2'd1;
  localparam logic [1:0] REG_TMA  = 2'd2;
  localparam logic [1:0] REG_TAC  = 2'd3;

  typedef struct packed {
    logic start_tick;    // load the tick: add cycles, subtract from counter if enabled
    logic start_access;  // perform a register access and load the result
    logic step;          // one DIV and/or TIMA step
    logic emit_tick;     // load the result of a finished tick
  } dtu_cmd_t;

  typedef struct packed {
    logic div_busy;      // accumulator still holds a full DIV period
    logic tmr_busy;      // enabled timer counter at zero or below
  } dtu_status_t;

  function automatic logic [PERIOD_W-1:0] rate_period(input logic [1:0] rate);
    logic [PERIOD_W-1:0] p;
    case (rate)
      2'd0:    p = 11'd1024;
      2'd1:    p = 11'd16;
      2'd2:    p = 11'd64;
      default: p = 11'd256;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/divider_and_timer_unit.sv -----
// Top level of the divider and timer unit (DIV / TIMA / TMA / TAC).
// Depends on dtu_pkg, dtu_ctrl and dtu_datapath.

// Timer block of a handheld console. Each request is a tick of in_cycle_count
// machine cycles (func 0), a register read (func 1) or a register write
// (func 2); func 3 changes nothing and returns zeros. Every request returns
// exactly one result. A register access returns its result in the cycle after
// the request is taken. A tick walks its step loop while a DIV or TIMA step is
// left, then emits its result; the DIV and timer loops share step cycles, with
// one DIV increment and one TIMA step resolved per cycle. With DIV_PERIOD at
// 256 a tick makes at most one DIV step; TIMA can step up to sixteen times
// per tick at the fastest rate. The request side stalls while a tick is being
// worked off, and while a result is held on a stalled output; a new request
// can be taken in the same cycle the previous result leaves.
module divider_and_timer_unit #(
  parameter int unsigned DIV_PERIOD = 256   // cycles per DIV increment, 16..256
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [1:0] in_reg_index,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_cycle_count,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_timer_irq,
  output logic       out_apu_div_pulse
);
  import dtu_pkg::*;

  dtu_cmd_t    cmd;
  dtu_status_t status;

  // Sequence requests: accept, walk the step loop, raise the result valid.
  dtu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the timer registers and the result payload.
  dtu_datapath #(
    .DIV_PERIOD (DIV_PERIOD)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_func           (in_func),
    .in_reg_index      (in_reg_index),
    .in_write_data     (in_write_data),
    .in_cycle_count    (in_cycle_count),
    .out_read_data     (out_read_data),
    .out_timer_irq     (out_timer_irq),
    .out_apu_div_pulse (out_apu_div_pulse)
  );

endmodule

// ----- hw/rtl/dtu_datapath.sv -----
// Datapath of the divider and timer unit: timer registers, step logic, result register.
// Depends on dtu_pkg and divider_and_timer_unit_defines.svh.
`include "divider_and_timer_unit_defines.svh"

module dtu_datapath #(
  parameter int unsigned DIV_PERIOD = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dtu_pkg::dtu_cmd_t   cmd,
  output dtu_pkg::dtu_status_t status,
  input  logic [1:0]          in_func,
  input  logic [1:0]          in_reg_index,
  input  logic [7:0]          in_write_data,
  input  logic [7:0]          in_cycle_count,
  output logic [7:0]          out_read_data,
  output logic                out_timer_irq,
  output logic                out_apu_div_pulse
);
  import dtu_pkg::*;

  localparam logic [ACCUM_W-1:0] PERIOD_C = ACCUM_W'(DIV_PERIOD);

  logic [ACCUM_W-1:0]  accum_r, accum_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [7:0]          div_r, div_nxt;
  logic [7:0]          tima_r, tima_nxt;
  logic [7:0]          tma_r, tma_nxt;
  logic [7:0]          tac_r, tac_nxt;
  logic                irq_flag_r, irq_flag_nxt;
  logic                pulse_flag_r, pulse_flag_nxt;
  logic [7:0]          rd_r, rd_nxt;
  logic                irq_out_r, irq_out_nxt;
  logic                pulse_out_r, pulse_out_nxt;
  logic [PERIOD_W-1:0] period;
  logic [16:0]         tac_sum;
  logic [15:0]         tac_sat;

  assign period          = rate_period(tac_r[1:0]);
  assign status.div_busy = (accum_r >= PERIOD_C);
  assign status.tmr_busy = tac_r[2] && (cnt_r[CNT_W-1] || (cnt_r == '0));

  always_comb begin
    accum_nxt      = accum_r;
    cnt_nxt        = cnt_r;
    div_nxt        = div_r;
    tima_nxt       = tima_r;
    tma_nxt        = tma_r;
    tac_nxt        = tac_r;
    irq_flag_nxt   = irq_flag_r;
    pulse_flag_nxt = pulse_flag_r;
    rd_nxt         = rd_r;
    irq_out_nxt    = irq_out_r;
    pulse_out_nxt  = pulse_out_r;
    tac_sum        = 17'({1'b0, cnt_r[15:0]}) + 17'(rate_period(in_write_data[1:0]));
    tac_sat        = tac_sum[16] ? 16'hFFFF : tac_sum[15:0];

    if (cmd.start_tick) begin
      accum_nxt      = accum_r + ACCUM_W'(in_cycle_count);
      irq_flag_nxt   = 1'b0;
      pulse_flag_nxt = 1'b0;
      if (tac_r[2]) begin
        cnt_nxt = cnt_r - CNT_W'(in_cycle_count);
      end
    end

    if (cmd.step) begin
      if (status.div_busy) begin
        accum_nxt = accum_r - PERIOD_C;
        div_nxt   = div_r + 8'd1;
        // bit 4 falls when the low five bits roll over
        if (div_r[4:0] == 5'h1F) begin
          pulse_flag_nxt = 1'b1;
        end
      end
      if (status.tmr_busy) begin
        cnt_nxt = cnt_r + CNT_W'(period);
        if (tima_r == 8'hFF) begin
          tima_nxt     = tma_r;
          irq_flag_nxt = 1'b1;
        end else begin
          tima_nxt = tima_r + 8'd1;
        end
      end
    end

    if (cmd.start_access) begin
      rd_nxt        = 8'd0;
      irq_out_nxt   = 1'b0;
      pulse_out_nxt = 1'b0;
      case (in_func)
        FUNC_READ: begin
          case (in_reg_index)
            REG_DIV:  rd_nxt = div_r;
            REG_TIMA: rd_nxt = tima_r;
            REG_TMA:  rd_nxt = tma_r;
            default:  rd_nxt = tac_r;
          endcase
        end
        FUNC_WRITE: begin
          case (in_reg_index)
            REG_DIV: begin
              pulse_out_nxt = div_r[4];
              div_nxt       = 8'd0;
            end
            REG_TIMA: tima_nxt = in_write_data;
            REG_TMA:  tma_nxt  = in_write_data;
            default: begin
              tac_nxt = in_write_data;
              if (in_write_data[1:0] != tac_r[1:0]) begin
                cnt_nxt = {1'b0, tac_sat};
              end
            end
          endcase
        end
        default: ;
      endcase
    end

    if (cmd.emit_tick) begin
      rd_nxt        = 8'd0;
      irq_out_nxt   = irq_flag_r;
      pulse_out_nxt = pulse_flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r      <= '0;
      cnt_r        <= CNT_W'(1024);
      div_r        <= '0;
      tima_r       <= '0;
      tma_r        <= '0;
      tac_r        <= '0;
      irq_flag_r   <= 1'b0;
      pulse_flag_r <= 1'b0;
    end else begin
      accum_r      <= accum_nxt;
      cnt_r        <= cnt_nxt;
      div_r        <= div_nxt;
      tima_r       <= tima_nxt;
      tma_r        <= tma_nxt;
      tac_r        <= tac_nxt;
      irq_flag_r   <= irq_flag_nxt;
      pulse_flag_r <= pulse_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r        <= rd_nxt;
    irq_out_r   <= irq_out_nxt;
    pulse_out_r <= pulse_out_nxt;
  end

  assign out_read_data     = rd_r;
  assign out_timer_irq     = irq_out_r;
  assign out_apu_div_pulse = pulse_out_r;

  // Outside a tick the timer counter always stays strictly positive.
  `DTU_ASSERT(a_cnt_positive_at_emit, clk, rst_n, cmd.emit_tick |-> (!cnt_r[CNT_W-1] && (cnt_r != '0)), "timer counter not positive at tick end")
  // A finished tick leaves less than one DIV period in the accumulator.
  `DTU_ASSERT(a_accum_drained, clk, rst_n, cmd.emit_tick |-> (accum_r < PERIOD_C), "divider accumulator not drained at tick end")

endmodule

// ----- hw/rtl/dtu_ctrl.sv -----
// Controller of the divider and timer unit: request handshake, step sequencing, result valid.
// Depends on dtu_pkg and divider_and_timer_unit_defines.svh.
`include "divider_and_timer_unit_defines.svh"

module dtu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_func,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  dtu_pkg::dtu_status_t status,
  output dtu_pkg::dtu_cmd_t    cmd
);
  import dtu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_STEP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   busy;

  // Take a request only when idle and the result slot is free or draining now.
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign busy     = status.div_busy || status.tmr_busy;

  always_comb begin
    cmd.start_tick   = accept && (in_func == FUNC_TICK);
    cmd.start_access = accept && (in_func != FUNC_TICK);
    cmd.step         = (state_r == ST_STEP) && busy;
    cmd.emit_tick    = (state_r == ST_STEP) && !busy;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd.start_tick) state_nxt = ST_STEP;
      ST_STEP: if (cmd.emit_tick) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.start_access || cmd.emit_tick) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A tick that runs out of steps must present its result next cycle.
  `DTU_ASSERT(a_emit_sets_valid, clk, rst_n, cmd.emit_tick |=> out_valid_r, "finished tick produced no result")
  // A new result never lands on one that is still held.
  `DTU_ASSERT(a_no_result_overwrite, clk, rst_n, (cmd.start_access || cmd.emit_tick) |-> !(out_valid_r && out_stall), "result overwritten while held")

endmodule
